// ===== rtl/s39ptm_pkg.sv =====
package s39ptm_pkg;

    // Field widths fixed by the request and result formats
    localparam int unsigned VPN_W    = 27;
    localparam int unsigned PPN_W    = 44;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned PERM_W   = 10;
    localparam int unsigned STATUS_W = 2;

    // Table geometry: 512 entries of 9 index bits per table page
    localparam int unsigned IDX_W    = 9;
    // Stored entry: PPN over the ten flag bits (upper PTE bits are always zero)
    localparam int unsigned ENTRY_W  = PPN_W + PERM_W;

    // Walk levels
    typedef enum logic [1:0] {
        LVL_LEAF = 2'd0,
        LVL_MID  = 2'd1,
        LVL_ROOT = 2'd2
    } level_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_POOL_FULL = 2'd1,
        STAT_OUT_POOL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic clear_wr;   // write zero during the reset clearing pass
        logic zero_wr;    // write zero into the page being allocated
        logic link_wr;    // write pointer PTE to the new page, descend
        logic descend;    // follow a valid pointer, descend
        logic leaf_wr;    // write leaf PTE, count it
        logic advance;    // step to the next virtual/physical page
        logic set_full;   // record pool exhausted
        logic set_range;  // record pointer outside pool
        logic publish;    // load the result register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic ent_valid;   // entry read at the current slot has V set
        logic in_range;    // its pointer lands inside the pool
        logic pool_full;   // no free table page left
        logic at_leaf;     // walk is at the last level
        logic count_zero;  // no pages left to map
        logic last_page;   // the current page is the last one
        logic zero_last;   // page zeroing reaches its last entry
        logic clear_last;  // reset clearing reaches its last entry
        logic out_free;    // result register can take a new result
    } stat_t;

endpackage

// ===== rtl/s39ptm_ctrl.sv =====
module s39ptm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  s39ptm_pkg::stat_t stat,
    output s39ptm_pkg::cmd_t  cmd
);

    s39ptm_pkg::state_t state_reg;
    s39ptm_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= s39ptm_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            s39ptm_pkg::S_CLEAR: begin
                if (stat.clear_last) state_next = s39ptm_pkg::S_IDLE;
            end
            s39ptm_pkg::S_IDLE: begin
                if (s_valid) state_next = s39ptm_pkg::S_START;
            end
            s39ptm_pkg::S_START: begin
                state_next = stat.count_zero ? s39ptm_pkg::S_DONE : s39ptm_pkg::S_READ;
            end
            s39ptm_pkg::S_READ: begin
                state_next = s39ptm_pkg::S_EVAL;
            end
            s39ptm_pkg::S_EVAL: begin
                if (stat.at_leaf) begin
                    state_next = stat.last_page ? s39ptm_pkg::S_DONE : s39ptm_pkg::S_READ;
                end else if (stat.ent_valid) begin
                    state_next = stat.in_range ? s39ptm_pkg::S_READ : s39ptm_pkg::S_DONE;
                end else begin
                    state_next = stat.pool_full ? s39ptm_pkg::S_DONE : s39ptm_pkg::S_ZERO;
                end
            end
            s39ptm_pkg::S_ZERO: begin
                if (stat.zero_last) state_next = s39ptm_pkg::S_LINK;
            end
            s39ptm_pkg::S_LINK: begin
                state_next = s39ptm_pkg::S_READ;
            end
            s39ptm_pkg::S_DONE: begin
                if (stat.out_free) state_next = s39ptm_pkg::S_IDLE;
            end
            default: state_next = s39ptm_pkg::S_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            s39ptm_pkg::S_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            s39ptm_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            s39ptm_pkg::S_EVAL: begin
                if (stat.at_leaf) begin
                    cmd.leaf_wr = !stat.ent_valid;
                    cmd.advance = 1'b1;
                end else if (stat.ent_valid) begin
                    cmd.descend   = stat.in_range;
                    cmd.set_range = !stat.in_range;
                end else begin
                    cmd.set_full = stat.pool_full;
                end
            end
            s39ptm_pkg::S_ZERO: begin
                cmd.zero_wr = 1'b1;
            end
            s39ptm_pkg::S_LINK: begin
                cmd.link_wr = 1'b1;
            end
            s39ptm_pkg::S_DONE: begin
                cmd.publish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/s39ptm_datapath.sv =====
module s39ptm_datapath #(
    parameter int unsigned TABLE_PAGES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [s39ptm_pkg::VPN_W-1:0]        s_virt_page,
    input  logic [s39ptm_pkg::PPN_W-1:0]        s_phys_page,
    input  logic [s39ptm_pkg::COUNT_W-1:0]      s_page_count,
    input  logic [s39ptm_pkg::PERM_W-1:0]       s_perm_bits,
    input  logic                                cfg_valid,
    input  logic [s39ptm_pkg::PPN_W-1:0]        cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [s39ptm_pkg::STATUS_W-1:0]     m_status,
    output logic [s39ptm_pkg::COUNT_W-1:0]      m_pages_installed,
    input  s39ptm_pkg::cmd_t                    cmd,
    output s39ptm_pkg::stat_t                   stat
);

    localparam int unsigned PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int unsigned NF_W   = $clog2(TABLE_PAGES + 1);
    localparam int unsigned ADDR_W = PAGE_W + s39ptm_pkg::IDX_W;
    localparam int unsigned DEPTH  = TABLE_PAGES << s39ptm_pkg::IDX_W;

    localparam logic [s39ptm_pkg::PPN_W-1:0] POOL_PAGES = s39ptm_pkg::PPN_W'(TABLE_PAGES);
    localparam logic [NF_W-1:0]              POOL_LIMIT = NF_W'(TABLE_PAGES);
    localparam logic [ADDR_W-1:0]            LAST_ADDR  = ADDR_W'(DEPTH - 1);

    // Table pool
    logic [s39ptm_pkg::ENTRY_W-1:0] mem [DEPTH];

    // Request and walk state
    logic [s39ptm_pkg::VPN_W-1:0]   va_reg, va_next;
    logic [s39ptm_pkg::PPN_W-1:0]   pa_reg, pa_next;
    logic [s39ptm_pkg::COUNT_W-1:0] remain_reg, remain_next;
    logic [s39ptm_pkg::PERM_W-1:0]  perm_reg, perm_next;
    logic [s39ptm_pkg::COUNT_W-1:0] installed_reg, installed_next;
    logic [PAGE_W-1:0]              page_reg, page_next;
    s39ptm_pkg::level_t             level_reg, level_next;
    s39ptm_pkg::status_t            status_reg, status_next;
    logic [NF_W-1:0]                next_free_reg, next_free_next;
    logic [ADDR_W-1:0]              clr_reg, clr_next;
    logic [s39ptm_pkg::PPN_W-1:0]   base_reg, base_next;
    logic [s39ptm_pkg::ENTRY_W-1:0] rdata_reg;

    // Result register
    logic                           m_valid_reg, m_valid_next;
    logic [s39ptm_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [s39ptm_pkg::COUNT_W-1:0] m_installed_reg, m_installed_next;

    logic [s39ptm_pkg::IDX_W-1:0]   vpn_idx;
    logic [ADDR_W-1:0]              slot_addr;
    logic [ADDR_W-1:0]              wr_addr;
    logic [s39ptm_pkg::ENTRY_W-1:0] wr_data;
    logic                           wr_en;
    logic [s39ptm_pkg::PPN_W-1:0]   ptr_ppn;
    logic [s39ptm_pkg::PPN_W-1:0]   ptr_idx;
    logic [s39ptm_pkg::PPN_W-1:0]   new_ppn;
    logic [PAGE_W-1:0]              new_page;

    // Select the VPN slice of the current level
    always_comb begin
        unique case (level_reg)
            s39ptm_pkg::LVL_ROOT: vpn_idx = va_reg[26:18];
            s39ptm_pkg::LVL_MID:  vpn_idx = va_reg[17:9];
            s39ptm_pkg::LVL_LEAF: vpn_idx = va_reg[8:0];
            default:              vpn_idx = va_reg[8:0];
        endcase
    end

    assign slot_addr = {page_reg, vpn_idx};
    assign new_page  = next_free_reg[PAGE_W-1:0];
    assign new_ppn   = base_reg + s39ptm_pkg::PPN_W'(next_free_reg);
    assign ptr_ppn   = rdata_reg[s39ptm_pkg::ENTRY_W-1:s39ptm_pkg::PERM_W];
    assign ptr_idx   = ptr_ppn - base_reg;

    // Memory write port: clearing, zeroing, pointer and leaf writes
    always_comb begin
        wr_en   = cmd.clear_wr | cmd.zero_wr | cmd.link_wr | cmd.leaf_wr;
        wr_addr = slot_addr;
        wr_data = '0;
        if (cmd.clear_wr) begin
            wr_addr = clr_reg;
        end else if (cmd.zero_wr) begin
            wr_addr = {new_page, clr_reg[s39ptm_pkg::IDX_W-1:0]};
        end else if (cmd.link_wr) begin
            wr_data = {new_ppn, s39ptm_pkg::PERM_W'(1)};
        end else if (cmd.leaf_wr) begin
            wr_data = {pa_reg, perm_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the current slot every cycle
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[slot_addr];
    end

    // Status toward the controller
    always_comb begin
        stat.ent_valid  = rdata_reg[0];
        stat.in_range   = ptr_idx < POOL_PAGES;
        stat.pool_full  = next_free_reg >= POOL_LIMIT;
        stat.at_leaf    = level_reg == s39ptm_pkg::LVL_LEAF;
        stat.count_zero = remain_reg == '0;
        stat.last_page  = remain_reg == s39ptm_pkg::COUNT_W'(1);
        stat.zero_last  = &clr_reg[s39ptm_pkg::IDX_W-1:0];
        stat.clear_last = clr_reg == LAST_ADDR;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // Next values
    always_comb begin
        va_next          = va_reg;
        pa_next          = pa_reg;
        remain_next      = remain_reg;
        perm_next        = perm_reg;
        installed_next   = installed_reg;
        page_next        = page_reg;
        level_next       = level_reg;
        status_next      = status_reg;
        next_free_next   = next_free_reg;
        clr_next         = clr_reg;
        base_next        = cfg_valid ? cfg_data : base_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_installed_next = m_installed_reg;

        if (cmd.load) begin
            va_next        = s_virt_page;
            pa_next        = s_phys_page;
            remain_next    = s_page_count;
            perm_next      = s_perm_bits;
            installed_next = '0;
            page_next      = '0;
            level_next     = s39ptm_pkg::LVL_ROOT;
            status_next    = s39ptm_pkg::STAT_DONE;
        end

        // Sweep counter for the reset pass and page zeroing
        if (cmd.clear_wr) begin
            clr_next = stat.clear_last ? '0 : clr_reg + ADDR_W'(1);
        end
        if (cmd.zero_wr) begin
            clr_next = stat.zero_last ? '0 : clr_reg + ADDR_W'(1);
        end

        // Descend through an existing or a fresh table page
        if (cmd.descend) begin
            page_next  = ptr_idx[PAGE_W-1:0];
            level_next = s39ptm_pkg::level_t'(level_reg - 2'd1);
        end
        if (cmd.link_wr) begin
            page_next      = new_page;
            level_next     = s39ptm_pkg::level_t'(level_reg - 2'd1);
            next_free_next = next_free_reg + NF_W'(1);
        end

        if (cmd.leaf_wr) begin
            installed_next = installed_reg + s39ptm_pkg::COUNT_W'(1);
        end
        if (cmd.advance) begin
            va_next     = va_reg + s39ptm_pkg::VPN_W'(1);
            pa_next     = pa_reg + s39ptm_pkg::PPN_W'(1);
            remain_next = remain_reg - s39ptm_pkg::COUNT_W'(1);
            page_next   = '0;
            level_next  = s39ptm_pkg::LVL_ROOT;
        end

        if (cmd.set_full)  status_next = s39ptm_pkg::STAT_POOL_FULL;
        if (cmd.set_range) status_next = s39ptm_pkg::STAT_OUT_POOL;

        if (cmd.publish) begin
            m_valid_next     = 1'b1;
            m_status_next    = status_reg;
            m_installed_next = installed_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_free_reg <= NF_W'(1);
            clr_reg       <= '0;
            base_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            next_free_reg <= next_free_next;
            clr_reg       <= clr_next;
            base_reg      <= base_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        va_reg          <= va_next;
        pa_reg          <= pa_next;
        remain_reg      <= remain_next;
        perm_reg        <= perm_next;
        installed_reg   <= installed_next;
        page_reg        <= page_next;
        level_reg       <= level_next;
        status_reg      <= status_next;
        m_status_reg    <= m_status_next;
        m_installed_reg <= m_installed_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_pages_installed = m_installed_reg;

    // Allocation never runs past the pool
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= POOL_LIMIT)
        else $error("free page counter beyond pool");

    // A pointer is linked only when a free page exists
    a_link_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.link_wr |-> !stat.pool_full)
        else $error("link with exhausted pool");

    // A leaf is written only over an invalid last-level entry
    a_leaf_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.leaf_wr |-> (stat.at_leaf && !rdata_reg[0]))
        else $error("leaf written over valid entry or at upper level");

    // At most one source drives the write port
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_wr, cmd.zero_wr, cmd.link_wr, cmd.leaf_wr}))
        else $error("conflicting memory writes");

    // A published result is loaded into the result register with the walk status
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> (m_valid_reg && m_status_reg == $past(status_reg)))
        else $error("result register not loaded");

endmodule

// ===== rtl/sv39_page_table_mapper.sv =====
// Flow: a start step, then per page a read and check of each of the three levels,
// plus, for each table page allocated, a 512-entry zeroing sweep and a pointer write;
// the result then moves to the output register. One request at a time; the next
// is taken once the result is registered, even while it still waits on m_ready.
// Reset: synchronous, active low; a clearing pass over all TABLE_PAGES*512 entries (32768 at
// 64 pages) zeroes the table memory through its single write port before the first request.
module sv39_page_table_mapper #(
    parameter int unsigned TABLE_PAGES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [s39ptm_pkg::VPN_W-1:0]        s_virt_page,
    input  logic [s39ptm_pkg::PPN_W-1:0]        s_phys_page,
    input  logic [s39ptm_pkg::COUNT_W-1:0]      s_page_count,
    input  logic [s39ptm_pkg::PERM_W-1:0]       s_perm_bits,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [s39ptm_pkg::PPN_W-1:0]        cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [s39ptm_pkg::STATUS_W-1:0]     m_status,
    output logic [s39ptm_pkg::COUNT_W-1:0]      m_pages_installed
);

    s39ptm_pkg::cmd_t  cmd;
    s39ptm_pkg::stat_t stat;

    // Accept base register writes at any time
    assign cfg_ready = 1'b1;

    s39ptm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    s39ptm_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_virt_page       (s_virt_page),
        .s_phys_page       (s_phys_page),
        .s_page_count      (s_page_count),
        .s_perm_bits       (s_perm_bits),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_pages_installed (m_pages_installed),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

// ===== tb/s39ptm_map_checker.sv =====
`timescale 1ns / 1ps

module s39ptm_map_checker #(
    parameter int unsigned TABLE_PAGES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [s39ptm_pkg::VPN_W-1:0]        s_virt_page,
    input  logic [s39ptm_pkg::PPN_W-1:0]        s_phys_page,
    input  logic [s39ptm_pkg::COUNT_W-1:0]      s_page_count,
    input  logic [s39ptm_pkg::PERM_W-1:0]       s_perm_bits,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [s39ptm_pkg::PPN_W-1:0]        cfg_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [s39ptm_pkg::STATUS_W-1:0]     m_status,
    input  logic [s39ptm_pkg::COUNT_W-1:0]      m_pages_installed,
    output int unsigned                         fail_count,
    output int unsigned                         results_due
);

    localparam int unsigned TABLE_ENTRIES = 1 << s39ptm_pkg::IDX_W;
    localparam int unsigned V_BIT         = 0;
    localparam logic [s39ptm_pkg::PERM_W-1:0] PTE_V = 10'h001;

    typedef struct packed {
        s39ptm_pkg::status_t             status;
        logic [s39ptm_pkg::COUNT_W-1:0]  pages;
    } map_outcome_t;

    // Shadow copy of the table pool and the allocator
    logic [s39ptm_pkg::ENTRY_W-1:0] table_mem [TABLE_PAGES*TABLE_ENTRIES];
    int unsigned                    alloc_next;
    logic [s39ptm_pkg::PPN_W-1:0]   root_ppn;

    map_outcome_t                   map_outcomes[$];
    map_outcome_t                   due_outcome;
    s39ptm_pkg::status_t            walk_status;
    logic [s39ptm_pkg::COUNT_W-1:0] walk_fresh;

    // Follow a valid entry as a pointer, or allocate and link a zeroed table page
    function automatic s39ptm_pkg::status_t descend_or_alloc(input int unsigned slot,
                                                             output int unsigned page);
        logic [s39ptm_pkg::PPN_W-1:0] ptr_ppn;
        logic [s39ptm_pkg::PPN_W-1:0] offset;
        page = 0;
        if (table_mem[slot][V_BIT]) begin
            ptr_ppn = table_mem[slot][s39ptm_pkg::ENTRY_W-1:s39ptm_pkg::PERM_W];
            offset  = ptr_ppn - root_ppn;
            if (offset >= TABLE_PAGES)
                return s39ptm_pkg::STAT_OUT_POOL;
            page = offset[31:0];
            return s39ptm_pkg::STAT_DONE;
        end
        if (alloc_next >= TABLE_PAGES)
            return s39ptm_pkg::STAT_POOL_FULL;
        page = alloc_next;
        alloc_next++;
        for (int unsigned k = 0; k < TABLE_ENTRIES; k++)
            table_mem[page*TABLE_ENTRIES + k] = '0;
        table_mem[slot] = {root_ppn + s39ptm_pkg::PPN_W'(page), PTE_V};
        return s39ptm_pkg::STAT_DONE;
    endfunction

    // Walk and install every page of one request, stop on the first failure
    function automatic void map_pages(input logic [s39ptm_pkg::VPN_W-1:0] vpn_first,
                                      input logic [s39ptm_pkg::PPN_W-1:0] ppn_first,
                                      input logic [s39ptm_pkg::COUNT_W-1:0] count,
                                      input logic [s39ptm_pkg::PERM_W-1:0] perm,
                                      output s39ptm_pkg::status_t st,
                                      output logic [s39ptm_pkg::COUNT_W-1:0] fresh);
        logic [s39ptm_pkg::VPN_W-1:0] vpn;
        logic [s39ptm_pkg::PPN_W-1:0] ppn;
        int unsigned                  mid_pg;
        int unsigned                  leaf_pg;
        int unsigned                  slot;
        vpn   = vpn_first;
        ppn   = ppn_first;
        st    = s39ptm_pkg::STAT_DONE;
        fresh = '0;
        for (int unsigned n = 0; n < count && st == s39ptm_pkg::STAT_DONE; n++) begin
            st = descend_or_alloc(32'(vpn[2*s39ptm_pkg::IDX_W +: s39ptm_pkg::IDX_W]),
                                  mid_pg);
            if (st == s39ptm_pkg::STAT_DONE)
                st = descend_or_alloc(mid_pg*TABLE_ENTRIES
                                      + 32'(vpn[s39ptm_pkg::IDX_W +: s39ptm_pkg::IDX_W]),
                                      leaf_pg);
            if (st == s39ptm_pkg::STAT_DONE) begin
                slot = leaf_pg*TABLE_ENTRIES + 32'(vpn[0 +: s39ptm_pkg::IDX_W]);
                if (!table_mem[slot][V_BIT]) begin
                    table_mem[slot] = {ppn, perm};
                    fresh++;
                end
                vpn = vpn + 1'b1;
                ppn = ppn + 1'b1;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (table_mem[k])
                table_mem[k] = '0;
            alloc_next = 1;
            root_ppn   = '0;
            map_outcomes.delete();
            fail_count  = 0;
            results_due = 0;
        end else begin
            // Track the base register
            if (cfg_valid && cfg_ready)
                root_ppn = cfg_data;

            // Compare a result transfer with the oldest outcome
            if (m_valid && m_ready) begin
                if (map_outcomes.size() == 0) begin
                    $error("m_status: result with no request pending, got %0d", m_status);
                    fail_count++;
                end else begin
                    due_outcome = map_outcomes.pop_front();
                    if (m_status !== due_outcome.status) begin
                        $error("m_status mismatch: expected %0d, got %0d",
                               due_outcome.status, m_status);
                        fail_count++;
                    end
                    if (m_pages_installed !== due_outcome.pages) begin
                        $error("m_pages_installed mismatch: expected %0d, got %0d",
                               due_outcome.pages, m_pages_installed);
                        fail_count++;
                    end
                end
            end

            // Predict the outcome of a request transfer
            if (s_valid && s_ready) begin
                map_pages(s_virt_page, s_phys_page, s_page_count, s_perm_bits,
                          walk_status, walk_fresh);
                map_outcomes.push_back('{status: walk_status, pages: walk_fresh});
            end

            results_due = map_outcomes.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned TABLE_PAGES = 64;
    localparam int unsigned RUN_LIMIT   = 8_000_000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned LONG_HOLD   = 20_000;
    localparam logic [s39ptm_pkg::PPN_W-1:0]   PPN_MAX   = '1;
    localparam logic [s39ptm_pkg::PPN_W-1:0]   PPN_HALF  = 44'h800_0000_0000;
    localparam logic [s39ptm_pkg::VPN_W-1:0]   VPN_MAX   = '1;
    localparam logic [s39ptm_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [s39ptm_pkg::PERM_W-1:0]  PERM_MAX  = '1;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                               aclk              = 1'b0;
    logic                               aresetn           = 1'b0;
    logic                               s_valid           = 1'b0;
    logic                               s_ready;
    logic [s39ptm_pkg::VPN_W-1:0]       s_virt_page       = '0;
    logic [s39ptm_pkg::PPN_W-1:0]       s_phys_page       = '0;
    logic [s39ptm_pkg::COUNT_W-1:0]     s_page_count      = '0;
    logic [s39ptm_pkg::PERM_W-1:0]      s_perm_bits       = '0;
    logic                               cfg_valid         = 1'b0;
    logic                               cfg_ready;
    logic [s39ptm_pkg::PPN_W-1:0]       cfg_data          = '0;
    logic                               m_valid;
    logic                               m_ready           = 1'b0;
    logic [s39ptm_pkg::STATUS_W-1:0]    m_status;
    logic [s39ptm_pkg::COUNT_W-1:0]     m_pages_installed;

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned send_pct    = 0;
    int unsigned stall_pct   = 0;
    bit          hold_on     = 1'b0;
    int unsigned hold_count  = 0;
    int unsigned cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sv39_page_table_mapper #(
        .TABLE_PAGES       (TABLE_PAGES)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_virt_page       (s_virt_page),
        .s_phys_page       (s_phys_page),
        .s_page_count      (s_page_count),
        .s_perm_bits       (s_perm_bits),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_pages_installed (m_pages_installed)
    );

    s39ptm_map_checker #(
        .TABLE_PAGES       (TABLE_PAGES)
    ) i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_virt_page       (s_virt_page),
        .s_phys_page       (s_phys_page),
        .s_page_count      (s_page_count),
        .s_perm_bits       (s_perm_bits),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_pages_installed (m_pages_installed),
        .fail_count        (fail_count),
        .results_due       (results_due)
    );

    // Result side: a one-time long hold-off, otherwise random stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_on && hold_count < LONG_HOLD) begin
                m_ready <= 1'b0;
                hold_count++;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_pct  = 77;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_pct  = 0;
                stall_pct = 77;
            end
            default: begin
                send_pct  = 35;
                stall_pct = 35;
            end
        endcase
    endtask

    // Offer one request after a random gap and hold it until the transfer
    task automatic send_request(input logic [s39ptm_pkg::VPN_W-1:0] vpn,
                                input logic [s39ptm_pkg::PPN_W-1:0] ppn,
                                input logic [s39ptm_pkg::COUNT_W-1:0] cnt,
                                input logic [s39ptm_pkg::PERM_W-1:0] perm);
        @(negedge aclk);
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_virt_page  <= vpn;
        s_phys_page  <= ppn;
        s_page_count <= cnt;
        s_perm_bits  <= perm;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every outcome has been returned
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due != 0)
            @(negedge aclk);
    endtask

    task automatic write_base(input logic [s39ptm_pkg::PPN_W-1:0] base);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Keep most requests in a few hot table regions so tables get reused
    task automatic send_random_request();
        logic [s39ptm_pkg::IDX_W-1:0]   hi;
        logic [s39ptm_pkg::IDX_W-1:0]   mid;
        logic [s39ptm_pkg::IDX_W-1:0]   lo;
        logic [s39ptm_pkg::VPN_W-1:0]   vpn;
        logic [s39ptm_pkg::PPN_W-1:0]   ppn;
        logic [s39ptm_pkg::COUNT_W-1:0] cnt;
        logic [s39ptm_pkg::PERM_W-1:0]  perm;
        int unsigned                    pick;
        case ($urandom_range(3))
            0: hi = 9'h000;
            1: hi = 9'h001;
            2: hi = 9'h002;
            default: hi = 9'h1FF;
        endcase
        case ($urandom_range(4))
            0: mid = 9'h000;
            1: mid = 9'h001;
            2: mid = 9'h100;
            3: mid = 9'h1FE;
            default: mid = 9'h1FF;
        endcase
        lo = ($urandom_range(3) == 0)
             ? (9'h1F0 | s39ptm_pkg::IDX_W'($urandom_range(15)))
             : s39ptm_pkg::IDX_W'($urandom);
        vpn = {hi, mid, lo};
        if ($urandom_range(199) == 0)
            vpn = s39ptm_pkg::VPN_W'($urandom);

        ppn = s39ptm_pkg::PPN_W'({$urandom, $urandom});
        if ($urandom_range(7) == 0)
            ppn = PPN_MAX - $urandom_range(15);

        perm = s39ptm_pkg::PERM_W'($urandom);
        if ($urandom_range(3) != 0)
            perm[0] = 1'b1;

        pick = $urandom_range(99);
        if (pick < 5)
            cnt = '0;
        else if (pick < 75)
            cnt = s39ptm_pkg::COUNT_W'($urandom_range(8, 1));
        else if (pick < 97)
            cnt = s39ptm_pkg::COUNT_W'($urandom_range(40, 9));
        else
            cnt = s39ptm_pkg::COUNT_W'($urandom_range(600, 41));

        send_request(vpn, ppn, cnt, perm);
    endtask

    // Rotate the idling pattern every fifty requests
    task automatic run_random(input int unsigned n_items);
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 50 == 0)
                set_idling(idle_mode_t'((i / 50) % 4));
            send_random_request();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests with the root at page zero
        set_idling(IDLE_NONE);
        write_base('0);
        send_request('0, '0, 20'd1, 10'h00F);
        send_request('0, '0, 20'd1, 10'h00F);
        send_request('0, PPN_MAX, '0, PERM_MAX);
        send_request(VPN_MAX, PPN_MAX, 20'd3, PERM_MAX);
        send_request(27'h0000020, 44'h123, 20'd2, 10'h00E);
        send_request(27'h0000020, 44'h456, 20'd3, 10'h0CF);
        send_request(27'h00001FE, 44'hABCDE, 20'd4, 10'h0C7);
        send_request(27'h003FFFF, '0, 20'd2, PERM_MAX);
        send_request(27'h5A5A5A5, 44'h555_5555_5555, 20'd1, 10'h155);
        send_request(27'h7FFFE00, 44'hAAA_AAAA_AAAA, 20'd1, 10'h2AA);

        // Hold results back long enough to stall the request side
        wait_idle();
        hold_on = 1'b1;
        repeat (8) send_random_request();
        hold_on = 1'b0;
        wait_idle();

        run_random(700);

        // Move the base far away: existing root pointers now leave the pool
        write_base(PPN_HALF);
        set_idling(IDLE_NONE);
        send_request('0, '0, COUNT_MAX, 10'h00F);
        send_request(VPN_MAX, PPN_MAX, COUNT_MAX, '0);
        send_request({9'd7, 18'd0}, 44'h777, 20'd2, 10'h00F);
        run_random(150);

        // Base at the top: existing pointers resolve to shifted pages
        write_base(PPN_MAX);
        run_random(300);

        // Back to zero, then walk fresh tables until the pool runs out
        write_base('0);
        set_idling(IDLE_NONE);
        send_request({9'd100, 18'd0}, 44'h1000, COUNT_MAX, 10'h0CF);
        run_random(380);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
